FILE: rtl/laa_pkg.sv
// Package for the latching alarm annunciator.
// Holds the beat structs, command codes and register indexes shared by all rtl files.
// Depends on nothing.
package laa_pkg;

    localparam int MASK_W      = 16;
    localparam int ID_W        = 4;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_ACK_ALL = 2'd2
    } laa_cmd_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALARMS_IN_USE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATCHING_MODE = 2'd1;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [ID_W-1:0] alarm_id;
        logic            condition;
    } laa_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] active_mask;
        logic [MASK_W-1:0] unacked_mask;
        logic              id_accepted;
    } laa_result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] alarms_in_use;
        logic               latching_mode;
    } laa_cfg_t;

endpackage

FILE: rtl/laa_cfg_regs.sv
// Configuration registers of the latching alarm annunciator.
// Uses laa_pkg for the register indexes and the configuration struct.
module laa_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [laa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [laa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output laa_pkg::laa_cfg_t                 cfg
);
    import laa_pkg::*;

    laa_cfg_t cfg_reg;

    // Every write is taken as soon as it is offered, so the channel never pushes back.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarms_in_use <= COUNT_W'(16);
            cfg_reg.latching_mode <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ALARMS_IN_USE: cfg_reg.alarms_in_use <= cfg_data[COUNT_W-1:0];
                CFG_LATCHING_MODE: cfg_reg.latching_mode <= cfg_data[0];
                default:           ;
            endcase
        end
    end

endmodule

FILE: rtl/laa_core.sv
// Alarm state bits, event logic and result register of the annunciator.
// Uses laa_pkg for the beat structs and command codes.
module laa_core #(
    parameter int ALARM_COUNT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  laa_pkg::laa_item_t   item,
    input  laa_pkg::laa_cfg_t    cfg,
    output logic                 result_valid,
    output laa_pkg::laa_result_t result
);
    import laa_pkg::*;

    logic [ALARM_COUNT-1:0] live_reg, live_next;
    logic [ALARM_COUNT-1:0] latched_reg, latched_next;
    logic [ALARM_COUNT-1:0] acked_reg, acked_next;
    logic                   result_valid_reg;
    laa_result_t            result_reg, result_next;

    logic [ALARM_COUNT-1:0] use_mask;
    logic [ALARM_COUNT-1:0] sel;
    logic [ALARM_COUNT-1:0] ack_mask;
    logic [ALARM_COUNT-1:0] clr;
    logic [ALARM_COUNT-1:0] act;
    logic [ALARM_COUNT-1:0] unack;
    logic                   accepted;

    // A count above the number of alarms saturates on its own, since every
    // index here is below the alarm count.
    always_comb
    begin
        for (int i = 0; i < ALARM_COUNT; i++)
        begin
            use_mask[i] = cfg.alarms_in_use > COUNT_W'(i);
            sel[i]      = use_mask[i] && (item.alarm_id == ID_W'(i));
        end
    end

    always_comb
    begin
        live_next    = live_reg;
        latched_next = latched_reg;
        acked_next   = acked_reg;
        accepted     = 1'b0;
        ack_mask     = '0;
        case (item.cmd)
            CMD_UPDATE:
            begin
                accepted = |sel;
                if (item.condition)
                begin
                    live_next    = live_reg | sel;
                    latched_next = latched_reg | sel;
                end
                else
                begin
                    live_next    = live_reg & ~sel;
                    latched_next = latched_reg & ~(sel & acked_reg);
                    acked_next   = acked_reg & ~sel;
                end
            end
            CMD_ACK:
            begin
                accepted = |sel;
                ack_mask = sel;
            end
            CMD_ACK_ALL:
            begin
                accepted = 1'b1;
                ack_mask = use_mask;
            end
            default: ;
        endcase
        // Acknowledge of an alarm whose condition is gone clears it outright.
        clr = ack_mask & ~live_reg;
        if (ack_mask != '0)
        begin
            latched_next = latched_reg & ~clr;
            acked_next   = (acked_reg | ack_mask) & ~clr;
        end
    end

    always_comb
    begin
        if (cfg.latching_mode)
            act = (live_next | (latched_next & ~acked_next)) & use_mask;
        else
            act = live_next & use_mask;
        unack = act & ~acked_next;
        result_next.active_mask  = MASK_W'(act);
        result_next.unacked_mask = MASK_W'(unack);
        result_next.id_accepted  = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg         <= '0;
            latched_reg      <= '0;
            acked_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= item_valid;
            if (item_valid)
            begin
                live_reg    <= live_next;
                latched_reg <= latched_next;
                acked_reg   <= acked_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/latching_alarm_annunciator.sv
// Top level of the latching alarm annunciator.
// Depends on laa_pkg, laa_cfg_regs and laa_core.
//
// Channel   Handshake               Payload
// -------   ---------------------   ---------------------------------------------
// command   start, busy             item   (cmd, alarm_id, condition)
// result    result_valid (strobe)   result (active_mask, unacked_mask, id_accepted)
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A command beat is taken at any edge with start high and busy low. Busy is
// always low: the block takes one command per cycle. Each command lands in
// the input register, and in the next cycle its result is captured in the result
// register, together with the result strobe.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears every alarm's live, latched and acknowledged bits and loads
// sixteen alarms in use with latching mode on.
module latching_alarm_annunciator #(
    parameter int ALARM_COUNT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  laa_pkg::laa_item_t                item,
    output logic                              result_valid,
    output laa_pkg::laa_result_t              result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [laa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [laa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import laa_pkg::*;

    laa_item_t item_reg;
    logic      item_valid_reg;
    laa_cfg_t  cfg;

    // The event logic keeps up with one command per cycle, so the command
    // side is never held off.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            item_reg <= item;
    end

    laa_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // State bits and masks are updated from the registered command, and
    // the new masks are captured in the result register.
    laa_core #(
        .ALARM_COUNT (ALARM_COUNT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid_reg),
        .item         (item_reg),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: tb/sv/latching_alarm_annunciator_tb.sv
// Self-checking testbench for the latching alarm annunciator.
// Depends on laa_pkg and latching_alarm_annunciator from the rtl folder.
// A mirror of the alarm bits predicts the masks of every result beat.
module latching_alarm_annunciator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import laa_pkg::*;

    // Command code outside the enum; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Register indexes with no register behind them; writes must have no effect.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int PHASES       = 12;
    localparam int PHASE_BEATS  = 150;

    // Mirror of the alarm state. Every accepted command beat is applied to the
    // mirror at once, and the masks it leaves behind are queued until the
    // block shows its result beat.
    class alarm_scoreboard;
        logic [MASK_W-1:0]  live;
        logic [MASK_W-1:0]  latched;
        logic [MASK_W-1:0]  acked;
        logic [COUNT_W-1:0] in_use;
        logic               latching;
        laa_result_t        awaited_masks[$];
        int unsigned        mismatches;

        function new();
            live       = '0;
            latched    = '0;
            acked      = '0;
            in_use     = COUNT_W'(16);
            latching   = 1'b1;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == CFG_ALARMS_IN_USE)
                in_use = data[COUNT_W-1:0];
            else if (index == CFG_LATCHING_MODE)
                latching = data[0];
        endfunction

        // Number of alarms in use, saturated at the number that exists.
        function int unsigned used_count();
            return (in_use > COUNT_W'(MASK_W)) ? MASK_W : int'(in_use);
        endfunction

        function logic [MASK_W-1:0] use_mask();
            logic [MASK_W:0] m;
            m = (17'd1 << used_count()) - 17'd1;
            return m[MASK_W-1:0];
        endfunction

        // Acknowledge the alarms in m; those without a live condition drop
        // both their latch and their acknowledge.
        function void acknowledge(logic [MASK_W-1:0] m);
            logic [MASK_W-1:0] clr;
            acked   = acked | m;
            clr     = m & ~live;
            latched = latched & ~clr;
            acked   = acked & ~clr;
        endfunction

        function int unsigned pending();
            return awaited_masks.size();
        endfunction

        function void note_command(laa_item_t it);
            logic [MASK_W-1:0] use_bits;
            logic [MASK_W-1:0] bit_sel;
            logic [MASK_W-1:0] act;
            laa_result_t       exp_beat;
            use_bits = use_mask();
            bit_sel  = (16'd1 << it.alarm_id) & use_bits;
            exp_beat = '0;
            if (it.cmd == CMD_UPDATE)
            begin
                if (bit_sel != '0)
                begin
                    exp_beat.id_accepted = 1'b1;
                    if (it.condition)
                    begin
                        live    = live | bit_sel;
                        latched = latched | bit_sel;
                    end
                    else
                    begin
                        live = live & ~bit_sel;
                        if ((acked & bit_sel) != '0)
                        begin
                            latched = latched & ~bit_sel;
                            acked   = acked & ~bit_sel;
                        end
                    end
                end
            end
            else if (it.cmd == CMD_ACK)
            begin
                if (bit_sel != '0)
                begin
                    exp_beat.id_accepted = 1'b1;
                    acknowledge(bit_sel);
                end
            end
            else if (it.cmd == CMD_ACK_ALL)
            begin
                exp_beat.id_accepted = 1'b1;
                acknowledge(use_bits);
            end
            act = latching ? (live | (latched & ~acked)) : live;
            act = act & use_bits;
            exp_beat.active_mask  = act;
            exp_beat.unacked_mask = act & ~acked;
            awaited_masks.push_back(exp_beat);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_masks(laa_result_t got);
            laa_result_t exp_beat;
            if (awaited_masks.size() == 0)
            begin
                report($sformatf("result beat with nothing expected (active %h unacked %h)",
                                 got.active_mask, got.unacked_mask));
            end
            else
            begin
                exp_beat = awaited_masks.pop_front();
                if (got.active_mask !== exp_beat.active_mask)
                    report($sformatf("active_mask %h, expected %h",
                                     got.active_mask, exp_beat.active_mask));
                if (got.unacked_mask !== exp_beat.unacked_mask)
                    report($sformatf("unacked_mask %h, expected %h",
                                     got.unacked_mask, exp_beat.unacked_mask));
                if (got.id_accepted !== exp_beat.id_accepted)
                    report($sformatf("id_accepted %b, expected %b",
                                     got.id_accepted, exp_beat.id_accepted));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    laa_item_t              item;
    logic                   result_valid;
    laa_result_t            result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    alarm_scoreboard scoreboard = new();

    latching_alarm_annunciator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // All sampling happens at the rising edge, on the values settled since the
    // falling edge. A result beat always belongs to a command taken at an earlier
    // edge, so checking and noting in the same edge cannot interfere.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                scoreboard.check_masks(result);
            if (start && !busy)
                scoreboard.note_command(item);
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task pause(int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Present one command beat and hold it until the block takes it.
    task send_command(logic [1:0] cmd, logic [ID_W-1:0] alarm_id, logic condition);
        laa_item_t it;
        it.cmd       = cmd;
        it.alarm_id  = alarm_id;
        it.condition = condition;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Lower start and wait for every outstanding result beat. Every command
    // yields a result, so a short margin after the last one is enough.
    task drain();
        @(negedge clk);
        start <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Register writes only ever follow a drain, so the block is idle.
    task write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        scoreboard.write_register(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task set_mode(logic [COUNT_W-1:0] count, logic latching);
        drain();
        write_register(CFG_ALARMS_IN_USE, count);
        // Only bit 0 of the mode register matters; the rest are random.
        write_register(CFG_LATCHING_MODE,
                       {CFG_DATA_W'($urandom_range(0, 15)) << 1} | CFG_DATA_W'(latching));
    endtask

    // Random command, mostly updates and acknowledges aimed at alarms in use,
    // with a share of out-of-range numbers and the unused command code.
    task send_random_command();
        int unsigned      r;
        int unsigned      used;
        logic [1:0]       cmd;
        logic [ID_W-1:0]  alarm_id;
        r    = $urandom_range(0, 99);
        used = scoreboard.used_count();
        if (r < 50)
            cmd = CMD_UPDATE;
        else if (r < 80)
            cmd = CMD_ACK;
        else if (r < 93)
            cmd = CMD_ACK_ALL;
        else
            cmd = CMD_UNUSED;
        if (used > 0 && $urandom_range(0, 9) < 8)
            alarm_id = ID_W'($urandom_range(0, used - 1));
        else
            alarm_id = ID_W'($urandom_range(0, 15));
        send_command(cmd, alarm_id, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int unsigned count_pick;
        bit          bursty;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: sixteen alarms, latching on.
        send_command(CMD_UPDATE, 4'd0, 1'b1);    // raise the lowest alarm
        send_command(CMD_UPDATE, 4'd15, 1'b1);   // raise the highest alarm
        send_command(CMD_ACK, 4'd0, 1'b0);       // acknowledge while still live
        send_command(CMD_UPDATE, 4'd0, 1'b0);    // condition goes away after acknowledge
        send_command(CMD_UPDATE, 4'd15, 1'b0);   // goes away unacknowledged: stays latched
        send_command(CMD_ACK, 4'd15, 1'b1);      // acknowledge once gone: clears at once
        send_command(CMD_UPDATE, 4'd5, 1'b1);
        send_command(CMD_UPDATE, 4'd5, 1'b0);
        send_command(CMD_UPDATE, 4'd9, 1'b1);
        send_command(CMD_ACK_ALL, 4'd3, 1'b1);   // clears 5, acknowledges 9
        send_command(CMD_UNUSED, 4'd10, 1'b1);   // unused code is ignored
        send_command(CMD_ACK, 4'd7, 1'b0);       // acknowledge of an idle alarm

        // Non-latching mode with four alarms: numbers from four up are refused.
        set_mode(COUNT_W'(4), 1'b0);
        send_command(CMD_UPDATE, 4'd3, 1'b1);
        send_command(CMD_UPDATE, 4'd4, 1'b1);
        send_command(CMD_ACK, 4'd9, 1'b0);
        send_command(CMD_UPDATE, 4'd3, 1'b0);
        send_command(CMD_ACK_ALL, 4'd0, 1'b0);
        send_command(CMD_UNUSED, 4'd2, 1'b0);

        // No alarms in use: only acknowledge-all is accepted.
        set_mode(COUNT_W'(0), 1'b1);
        send_command(CMD_UPDATE, 4'd0, 1'b1);
        send_command(CMD_ACK_ALL, 4'd15, 1'b1);

        // A count beyond the alarms present saturates; spare indexes do nothing.
        set_mode(COUNT_W'(31), 1'b1);
        write_register(CFG_SPARE_LO, CFG_DATA_W'(0));
        write_register(CFG_SPARE_HI, CFG_DATA_W'(31));
        send_command(CMD_UPDATE, 4'd15, 1'b1);
        send_command(CMD_ACK, 4'd15, 1'b1);
        send_command(CMD_UPDATE, 4'd15, 1'b0);

        // Random phases, each at its own setting. The first few pin the
        // extremes of the count; later ones pick at random.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       count_pick = 16;
                1:       count_pick = 1;
                2:       count_pick = 0;
                3:       count_pick = 31;
                default: count_pick = ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(17, 31) : $urandom_range(1, 16);
            endcase
            set_mode(COUNT_W'(count_pick), phase[0] ^ 1'($urandom_range(0, 1)));
            bursty = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                send_random_command();
                if (!bursty)
                    pause(gap_length());
                // Hold the sender until the pipeline is empty, now and then
                // and once for sure in the middle of the first phase.
                if ((phase == 0 && n == PHASE_BEATS / 2) || $urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard limit well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
